FILE: design/tphi_pkg.sv
package tphi_pkg;

	localparam int NCOORD = 9;
	localparam int CW_BITS = 32;

	// Operation codes of the request channel.
	localparam logic [1:0] FUNC_RECORD = 2'd0;
	localparam logic [1:0] FUNC_QUERY  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	// Configuration register indexes.
	localparam logic REG_HISTORY_SLOTS = 1'b0;
	localparam logic REG_CLIENT_LIMIT  = 1'b1;

	localparam logic [5:0] HISTORY_SLOTS_RST = 6'd9;
	localparam logic [6:0] CLIENT_LIMIT_RST  = 7'd64;

	// Interpolation fraction of exactly one in Q1.16.
	localparam logic [16:0] FRAC_ONE = 17'h10000;

	// Origin xyz, box minimum xyz, box maximum xyz; element 0 is origin x.
	typedef logic [NCOORD-1:0][CW_BITS-1:0] coords_t;

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_META = 14'b00000000000010,
		S_MCAP = 14'b00000000000100,
		S_MODH = 14'b00000000001000,
		S_REC  = 14'b00000000010000,
		S_WRD  = 14'b00000000100000,
		S_WEV  = 14'b00000001000000,
		S_POST = 14'b00000010000000,
		S_CWB  = 14'b00000100000000,
		S_CWA  = 14'b00001000000000,
		S_DIV  = 14'b00010000000000,
		S_MUL  = 14'b00100000000000,
		S_ADD  = 14'b01000000000000,
		S_DONE = 14'b10000000000000
	} state_t;

	typedef struct packed {
		logic accept;
		logic meta_rd;
		logic meta_cap;
		logic mod_step;
		logic walk_init;
		logic rec_wr;
		logic stamp_rd;
		logic walk_ev;
		logic post;
		logic cap_b;
		logic copy_b;
		logic cap_a;
		logic f_zero;
		logic f_one;
		logic div_init;
		logic div_step;
		logic mul;
		logic add;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       client_act;
		logic       h_ge_n;
		logic       cnt_zero;
		logic       walk_end;
		logic       hb;
		logic       ha;
		logic       t_eq;
		logic       t_lt;
		logic       num_ge_den;
		logic       div_last;
		logic       k_last;
		logic       out_busy;
	} sts_t;

endpackage

FILE: design/tphi_if.sv
interface tphi_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [5:0]         client;
	logic signed [31:0] sample_time;
	logic signed [31:0] origin_x;
	logic signed [31:0] origin_y;
	logic signed [31:0] origin_z;
	logic signed [31:0] low_corner_x;
	logic signed [31:0] low_corner_y;
	logic signed [31:0] low_corner_z;
	logic signed [31:0] high_corner_x;
	logic signed [31:0] high_corner_y;
	logic signed [31:0] high_corner_z;

	modport source (
		output valid, func, client, sample_time, origin_x, origin_y, origin_z,
		output low_corner_x, low_corner_y, low_corner_z,
		output high_corner_x, high_corner_y, high_corner_z,
		input ready
	);
	modport sink (
		input valid, func, client, sample_time, origin_x, origin_y, origin_z,
		input low_corner_x, low_corner_y, low_corner_z,
		input high_corner_x, high_corner_y, high_corner_z,
		output ready
	);
endinterface

interface tphi_rsp_if;
	logic               valid;
	logic               ready;
	logic               found;
	logic signed [31:0] res_origin_x;
	logic signed [31:0] res_origin_y;
	logic signed [31:0] res_origin_z;
	logic signed [31:0] res_low_x;
	logic signed [31:0] res_low_y;
	logic signed [31:0] res_low_z;
	logic signed [31:0] res_high_x;
	logic signed [31:0] res_high_y;
	logic signed [31:0] res_high_z;

	modport source (
		output valid, found, res_origin_x, res_origin_y, res_origin_z,
		output res_low_x, res_low_y, res_low_z, res_high_x, res_high_y, res_high_z,
		input ready
	);
	modport sink (
		input valid, found, res_origin_x, res_origin_y, res_origin_z,
		input res_low_x, res_low_y, res_low_z, res_high_x, res_high_y, res_high_z,
		output ready
	);
endinterface

FILE: design/timestamped_position_history_interp.sv
// One transaction is in work at a time: clear and rejected items go straight to the
// result, a record reads and rewrites the ring metadata, and a query walks the ring,
// then divides and interpolates. Shrinking history_slots without clears adds a head
// fix-up that subtracts the ring length until the head lies inside the ring.
// Reset: asynchronous, active low; control, configuration and per-client row flags clear
// at once, so no clearing pass over the memories is needed.
module timestamped_position_history_interp
	import tphi_pkg::*;
#(
	parameter int CLIENTS = 64,
	parameter int SLOTS   = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [6:0] cfg_data,
	tphi_req_if.sink   req,
	tphi_rsp_if.source rsp
);
	// The controller sequences every transaction; the datapath owns the three
	// memories (per-client ring metadata, stamps and coordinates), the walk
	// registers, the serial divider and the shared multiplier.
	// The rate is set by the ring walk, which reads the stamps one at a time
	// through the stamp memory port, with a read state and an evaluate state for
	// each, and by the nine coordinates going one at a time through a single multiplier.
	// A finished result sits in the output register; the next request is
	// accepted while it waits, and only the final load waits for the sink.

	cmd_t    cmd;
	sts_t    sts;
	coords_t in_coords;
	coords_t out_coords;

	assign in_coords = {req.high_corner_z, req.high_corner_y, req.high_corner_x,
		req.low_corner_z, req.low_corner_y, req.low_corner_x,
		req.origin_z, req.origin_y, req.origin_x};

	tphi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tphi_dp #(.CLIENTS(CLIENTS), .SLOTS(SLOTS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.in_func    (req.func),
		.in_client  (req.client),
		.in_time    (req.sample_time),
		.in_coords  (in_coords),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_found  (rsp.found),
		.out_coords (out_coords),
		.cmd        (cmd),
		.sts        (sts)
	);

	// Result fields in the same order as the stored sample.
	assign rsp.res_origin_x = out_coords[0];
	assign rsp.res_origin_y = out_coords[1];
	assign rsp.res_origin_z = out_coords[2];
	assign rsp.res_low_x    = out_coords[3];
	assign rsp.res_low_y    = out_coords[4];
	assign rsp.res_low_z    = out_coords[5];
	assign rsp.res_high_x   = out_coords[6];
	assign rsp.res_high_y   = out_coords[7];
	assign rsp.res_high_z   = out_coords[8];
endmodule

FILE: design/tphi_ram.sv
module tphi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

FILE: design/tphi_ctrl.sv
module tphi_ctrl
	import tphi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_META;
				end
			end
			S_META: begin
				if ((sts.func == FUNC_RECORD || sts.func == FUNC_QUERY) && sts.client_act) begin
					cmd.meta_rd = 1'b1;
					state_d     = S_MCAP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_MCAP: begin
				cmd.meta_cap = 1'b1;
				state_d      = S_MODH;
			end
			S_MODH: begin
				if (sts.h_ge_n) begin
					cmd.mod_step = 1'b1;
				end else if (sts.func == FUNC_RECORD) begin
					state_d = S_REC;
				end else if (sts.cnt_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.walk_init = 1'b1;
					state_d       = S_WRD;
				end
			end
			S_REC: begin
				cmd.rec_wr = 1'b1;
				state_d    = S_DONE;
			end
			S_WRD: begin
				cmd.stamp_rd = 1'b1;
				state_d      = S_WEV;
			end
			S_WEV: begin
				cmd.walk_ev = 1'b1;
				state_d     = sts.walk_end ? S_POST : S_WRD;
			end
			S_POST: begin
				if (sts.hb) begin
					cmd.post = 1'b1;
					state_d  = S_CWB;
				end else begin
					state_d = S_DONE;
				end
			end
			S_CWB: begin
				cmd.cap_b = 1'b1;
				if (sts.ha) begin
					state_d = S_CWA;
				end else begin
					cmd.copy_b = 1'b1;
					state_d    = S_DONE;
				end
			end
			S_CWA: begin
				cmd.cap_a = 1'b1;
				if (sts.t_eq || sts.t_lt) begin
					cmd.f_zero = 1'b1;
					state_d    = S_MUL;
				end else if (sts.num_ge_den) begin
					cmd.f_one = 1'b1;
					state_d   = S_MUL;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = sts.k_last ? S_DONE : S_MUL;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

FILE: design/tphi_dp.sv
module tphi_dp
	import tphi_pkg::*;
#(
	parameter int CLIENTS = 64,
	parameter int SLOTS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [6:0]  cfg_data,
	input  logic [1:0]  in_func,
	input  logic [5:0]  in_client,
	input  logic [31:0] in_time,
	input  coords_t     in_coords,
	input  logic        out_ready,
	output logic        out_valid,
	output logic        out_found,
	output coords_t     out_coords,
	input  cmd_t        cmd,
	output sts_t        sts
);
	localparam int CW  = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
	localparam int CIW = (CW > 6) ? CW : 6;
	localparam int HW  = $clog2(SLOTS);
	localparam int NW  = $clog2(SLOTS + 1);
	localparam int AW  = $clog2(CLIENTS * SLOTS);
	localparam int MW  = NW + HW + SLOTS;

	// Configuration registers.
	logic [5:0] hs_q;
	logic [6:0] cl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q <= HISTORY_SLOTS_RST;
			cl_q <= CLIENT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HISTORY_SLOTS: hs_q <= cfg_data[5:0];
				REG_CLIENT_LIMIT:  cl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Ring length in use, clamped to 4..SLOTS.
	logic [8:0]    hs9;
	logic [NW-1:0] nlen;
	assign hs9  = 9'(hs_q);
	assign nlen = (hs9 < 9'd4) ? NW'(4) : (hs9 > 9'(SLOTS)) ? NW'(SLOTS) : NW'(hs9);

	// Captured request.
	logic [1:0]  func_q;
	logic [5:0]  client_q;
	logic [31:0] time_q;
	coords_t     cin_q;

	logic [CIW-1:0] cl_ext, in_cl_ext;
	logic [CW-1:0]  cidx, in_cidx;
	assign cl_ext    = CIW'(client_q);
	assign cidx      = cl_ext[CW-1:0];
	assign in_cl_ext = CIW'(in_client);
	assign in_cidx   = in_cl_ext[CW-1:0];

	function automatic logic [AW-1:0] slot_addr(input logic [CW-1:0] c, input logic [HW-1:0] s);
		slot_addr = AW'(c) * AW'(SLOTS) + AW'(s);
	endfunction

	// A row flag marks per-client metadata that has been written since reset or clear.
	logic [CLIENTS-1:0] row_ok_q;

	// Walk and interpolation state.
	logic [HW-1:0]      head_q, ptr_q, bs_q, as_q;
	logic [NW-1:0]      fill_q, rem_q;
	logic [SLOTS-1:0]   vrow_q;
	logic               hb_q, ha_q;
	logic signed [31:0] bt_q, at_q;
	logic [32:0]        num_q, den_q;
	coords_t            bco_q, aco_q;
	logic [16:0]        f_q;
	logic [33:0]        drem_q;
	logic [3:0]         dcnt_q, k_q;
	logic signed [50:0] prod_s1;
	coords_t            resw_q;
	logic               foundw_q;
	logic               ov_q, ofound_q;
	coords_t            ores_q;

	// Memories.
	logic [MW-1:0]             meta_rdata, meta_wdata;
	logic [31:0]               stamp_rdata;
	logic [NCOORD*CW_BITS-1:0] coord_rdata;
	logic [AW-1:0]             head_addr, ptr_addr;

	assign head_addr = slot_addr(cidx, head_q);
	assign ptr_addr  = slot_addr(cidx, ptr_q);

	logic [NW:0]    fill_inc;
	logic [HW-1:0]  head_next;
	logic [SLOTS-1:0] vrow_next;
	assign fill_inc  = (NW + 1)'(fill_q) + (NW + 1)'(1);
	assign head_next = ((NW'(head_q) + NW'(1)) == nlen) ? '0 : head_q + HW'(1);
	assign vrow_next = vrow_q | (SLOTS'(1) << head_q);
	assign meta_wdata = {(fill_inc < (NW + 1)'(nlen)) ? NW'(fill_inc) : nlen, head_next, vrow_next};

	tphi_ram #(.WIDTH(MW), .DEPTH(CLIENTS)) u_meta_ram (
		.clk     (clk),
		.wr_en   (cmd.rec_wr),
		.wr_addr ($clog2(CLIENTS)'(cidx)),
		.wr_data (meta_wdata),
		.rd_en   (cmd.meta_rd),
		.rd_addr ($clog2(CLIENTS)'(cidx)),
		.rd_data (meta_rdata)
	);

	tphi_ram #(.WIDTH(32), .DEPTH(CLIENTS * SLOTS)) u_stamp_ram (
		.clk     (clk),
		.wr_en   (cmd.rec_wr),
		.wr_addr (head_addr),
		.wr_data (time_q),
		.rd_en   (cmd.stamp_rd),
		.rd_addr (ptr_addr),
		.rd_data (stamp_rdata)
	);

	tphi_ram #(.WIDTH(NCOORD * CW_BITS), .DEPTH(CLIENTS * SLOTS)) u_coord_ram (
		.clk     (clk),
		.wr_en   (cmd.rec_wr),
		.wr_addr (head_addr),
		.wr_data (cin_q),
		.rd_en   (cmd.post || cmd.cap_b),
		.rd_addr (cmd.post ? slot_addr(cidx, bs_q) : slot_addr(cidx, as_q)),
		.rd_data (coord_rdata)
	);

	// Ring walk: evaluation of one stamp.
	logic signed [31:0] t_cur;
	logic               v_cur, le_cur, brk;
	logic               nhb, nha;
	logic signed [31:0] nbt, nat;
	logic [HW-1:0]      nbs, nas;
	logic [NW-1:0]      cnt;

	assign cnt   = (fill_q < nlen) ? fill_q : nlen;
	assign t_cur = $signed(stamp_rdata);
	assign v_cur = vrow_q[ptr_q];
	assign le_cur = t_cur <= $signed(time_q);

	always_comb begin
		nhb = hb_q;
		nha = ha_q;
		nbt = bt_q;
		nat = at_q;
		nbs = bs_q;
		nas = as_q;
		if (v_cur) begin
			if (le_cur) begin
				if (!hb_q || t_cur > bt_q) begin
					nhb = 1'b1;
					nbt = t_cur;
					nbs = ptr_q;
				end
			end else if (!ha_q || t_cur < at_q) begin
				nha = 1'b1;
				nat = t_cur;
				nas = ptr_q;
			end
		end
		brk = v_cur && nhb && nha && (t_cur < nbt);
	end

	// One restoring division step.
	logic [33:0] dsh;
	logic        dge;
	assign dsh = {drem_q[32:0], 1'b0};
	assign dge = dsh >= {1'b0, den_q};

	logic signed [32:0] cdiff;
	assign cdiff = $signed({aco_q[k_q][31], aco_q[k_q]}) - $signed({bco_q[k_q][31], bco_q[k_q]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (cmd.accept && in_func == FUNC_CLEAR && 9'(in_client) < 9'(CLIENTS)) begin
				row_ok_q[in_cidx] <= 1'b0;
			end
			if (cmd.rec_wr) begin
				row_ok_q[cidx] <= 1'b1;
			end
			if (cmd.out_load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q   <= in_func;
			client_q <= in_client;
			time_q   <= in_time;
			cin_q    <= in_coords;
			resw_q   <= '0;
			foundw_q <= 1'b0;
		end
		if (cmd.meta_cap) begin
			if (row_ok_q[cidx]) begin
				{fill_q, head_q, vrow_q} <= meta_rdata;
			end else begin
				{fill_q, head_q, vrow_q} <= '0;
			end
		end
		if (cmd.mod_step) begin
			head_q <= HW'(NW'(head_q) - nlen);
		end
		if (cmd.walk_init) begin
			ptr_q <= (head_q == '0) ? HW'(nlen - NW'(1)) : head_q - HW'(1);
			rem_q <= cnt;
			hb_q  <= 1'b0;
			ha_q  <= 1'b0;
		end
		if (cmd.walk_ev) begin
			hb_q  <= nhb;
			ha_q  <= nha;
			bt_q  <= nbt;
			at_q  <= nat;
			bs_q  <= nbs;
			as_q  <= nas;
			rem_q <= rem_q - NW'(1);
			ptr_q <= (ptr_q == '0) ? HW'(nlen - NW'(1)) : ptr_q - HW'(1);
		end
		if (cmd.post) begin
			num_q <= ($signed(time_q) > bt_q)
				? 33'($signed({time_q[31], time_q}) - $signed({bt_q[31], bt_q})) : '0;
			den_q <= (at_q > bt_q)
				? 33'($signed({at_q[31], at_q}) - $signed({bt_q[31], bt_q}))
				: 33'($signed({bt_q[31], bt_q}) - $signed({at_q[31], at_q}));
		end
		if (cmd.cap_b) begin
			bco_q <= coord_rdata;
		end
		if (cmd.copy_b) begin
			resw_q   <= coord_rdata;
			foundw_q <= 1'b1;
		end
		if (cmd.cap_a) begin
			aco_q <= coord_rdata;
			k_q   <= '0;
		end
		if (cmd.f_zero) begin
			f_q <= '0;
		end
		if (cmd.f_one) begin
			f_q <= FRAC_ONE;
		end
		if (cmd.div_init) begin
			f_q    <= '0;
			drem_q <= 34'(num_q);
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			drem_q <= dge ? dsh - {1'b0, den_q} : dsh;
			f_q    <= {f_q[15:0], dge};
			dcnt_q <= dcnt_q + 4'd1;
		end
		if (cmd.mul) begin
			prod_s1 <= $signed({1'b0, f_q}) * cdiff;
		end
		if (cmd.add) begin
			resw_q[k_q] <= bco_q[k_q] + prod_s1[47:16];
			foundw_q    <= 1'b1;
			k_q         <= k_q + 4'd1;
		end
		if (cmd.out_load) begin
			ofound_q <= foundw_q;
			ores_q   <= resw_q;
		end
	end

	assign sts.func       = func_q;
	assign sts.client_act = (7'(client_q) < cl_q) && (9'(client_q) < 9'(CLIENTS));
	assign sts.h_ge_n     = NW'(head_q) >= nlen;
	assign sts.cnt_zero   = (cnt == '0);
	assign sts.walk_end   = brk || (rem_q == NW'(1));
	assign sts.hb         = hb_q;
	assign sts.ha         = ha_q;
	assign sts.t_eq       = (at_q == bt_q);
	assign sts.t_lt       = (at_q < bt_q);
	assign sts.num_ge_den = (num_q >= den_q);
	assign sts.div_last   = (dcnt_q == 4'd15);
	assign sts.k_last     = (k_q == 4'(NCOORD - 1));
	assign sts.out_busy   = ov_q && !out_ready;

	assign out_valid  = ov_q;
	assign out_found  = ofound_q;
	assign out_coords = ores_q;
endmodule

FILE: design/tphi_checker.sv
module tphi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        found,
	input logic [31:0] r0,
	input logic [31:0] r1,
	input logic [31:0] r2,
	input logic [31:0] r3,
	input logic [31:0] r4,
	input logic [31:0] r5,
	input logic [31:0] r6,
	input logic [31:0] r7,
	input logic [31:0] r8
);
	logic [1:0] pend_q;
	logic       acc, del;

	assign acc = req_valid && req_ready;
	assign del = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else if (acc && !del) begin
			pend_q <= pend_q + 2'd1;
		end else if (del && !acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result transaction dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !req_ready)
		else $error("request accepted in back-to-back cycles");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("result transaction without a pending request");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found |-> (r0 == 32'd0 && r1 == 32'd0 && r2 == 32'd0 && r3 == 32'd0
			&& r4 == 32'd0 && r5 == 32'd0 && r6 == 32'd0 && r7 == 32'd0 && r8 == 32'd0))
		else $error("result without position carries nonzero coordinates");
endmodule

bind timestamped_position_history_interp tphi_checker u_tphi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.found     (rsp.found),
	.r0        (rsp.res_origin_x),
	.r1        (rsp.res_origin_y),
	.r2        (rsp.res_origin_z),
	.r3        (rsp.res_low_x),
	.r4        (rsp.res_low_y),
	.r5        (rsp.res_low_z),
	.r6        (rsp.res_high_x),
	.r7        (rsp.res_high_y),
	.r8        (rsp.res_high_z)
);

FILE: tb/timestamped_position_history_interp_tb.sv
`timescale 1ns / 100ps

module timestamped_position_history_interp_tb;
	import tphi_pkg::*;

	localparam int N_CLIENTS = 64;
	localparam int N_SLOTS   = 32;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [1:0]  func;
		logic [5:0]  client;
		logic [31:0] stamp;
		coords_t     box;
	} req_item_t;

	typedef struct {
		logic    found;
		coords_t box;
	} rsp_item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_idx;
	logic [6:0] cfg_data;

	tphi_req_if req ();
	tphi_rsp_if rsp ();

	timestamped_position_history_interp uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
	);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	// Shadow copy of the history storage. Entries only matter where the
	// valid bit is set, so only the valid bits, heads and fills start at zero, like the block's flags.
	coords_t     hist_box   [N_CLIENTS][N_SLOTS];
	logic [31:0] hist_stamp [N_CLIENTS][N_SLOTS];
	bit          hist_valid [N_CLIENTS][N_SLOTS];
	int unsigned hist_head  [N_CLIENTS];
	int unsigned hist_fill  [N_CLIENTS];
	logic [5:0]  ring_cfg;
	logic [6:0]  limit_cfg;

	req_item_t pending_reqs[$];
	rsp_item_t expected_rsps[$];

	int  send_idle_pct;
	int  recv_stall_pct;
	int  errors;
	int  n_sent;
	int  n_rsps;
	int  n_found;
	int  idle_cycles;
	bit  timed_out;
	bit  req_taken;

	function automatic int unsigned ring_length();
		int unsigned n;
		n = ring_cfg;
		if (n < 4) n = 4;
		if (n > N_SLOTS) n = N_SLOTS;
		return n;
	endfunction

	// Floor of a signed product divided by 65536.
	function automatic longint floor_frac(longint p);
		if (p >= 0) return p >>> 16;
		return -((-p + 65535) >>> 16);
	endfunction

	// Answer a query against the shadow ring of one client.
	function automatic rsp_item_t lookup_position(int c, longint target);
		rsp_item_t r;
		int unsigned n, h, cnt, s, bs, as_;
		longint t, bt, at, num, den, f, b, a;
		bit hb, ha;
		r.found = 1'b0;
		r.box = '0;
		n = ring_length();
		h = hist_head[c] % n;
		cnt = (hist_fill[c] < n) ? hist_fill[c] : n;
		hb = 0; ha = 0; bs = 0; as_ = 0; bt = 0; at = 0;
		for (int i = 0; i < cnt; i++) begin
			s = (h + n - 1 - i) % n;
			if (!hist_valid[c][s]) continue;
			t = longint'(signed'(hist_stamp[c][s]));
			if (t <= target) begin
				if (!hb || t > bt) begin
					hb = 1; bt = t; bs = s;
				end
			end else if (!ha || t < at) begin
				ha = 1; at = t; as_ = s;
			end
			// Once both neighbors exist, an older sample below "before" ends the walk.
			if (hb && ha && t < bt) break;
		end
		if (!hb) return r;
		r.found = 1'b1;
		if (!ha) begin
			r.box = hist_box[c][bs];
			return r;
		end
		if (at == bt) begin
			f = 0;
		end else begin
			num = (target > bt) ? target - bt : 0;
			den = (at > bt) ? at - bt : bt - at;
			f = (num <<< 16) / den;
			if (at < bt) f = 0;
			if (f > 65536) f = 65536;
		end
		for (int k = 0; k < NCOORD; k++) begin
			b = longint'(signed'(hist_box[c][bs][k]));
			a = longint'(signed'(hist_box[c][as_][k]));
			r.box[k] = 32'(b + floor_frac(f * (a - b)));
		end
		return r;
	endfunction

	// Apply one accepted transaction to the shadow state and return its result.
	function automatic rsp_item_t predict_history(req_item_t it);
		rsp_item_t r;
		int unsigned n, idx, active;
		int c;
		r.found = 1'b0;
		r.box = '0;
		c = it.client;
		active = (limit_cfg < N_CLIENTS) ? limit_cfg : N_CLIENTS;
		case (it.func)
			FUNC_RECORD: begin
				if (c < active) begin
					n = ring_length();
					idx = hist_head[c] % n;
					hist_box[c][idx] = it.box;
					hist_stamp[c][idx] = it.stamp;
					hist_valid[c][idx] = 1;
					hist_head[c] = (idx + 1) % n;
					hist_fill[c] = (hist_fill[c] + 1 < n) ? hist_fill[c] + 1 : n;
				end
			end
			FUNC_QUERY: begin
				if (c < active) r = lookup_position(c, longint'(signed'(it.stamp)));
			end
			FUNC_CLEAR: begin
				for (int s = 0; s < N_SLOTS; s++) hist_valid[c][s] = 0;
				hist_head[c] = 0;
				hist_fill[c] = 0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Driver: presents the oldest pending transaction, holding it until taken.
	// The monitor removes a transaction from the queue at the accepting edge.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (!req.valid || req_taken) begin
				req_taken = 1'b0;
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_item_t it;
					it = pending_reqs[0];
					req.valid <= 1'b1;
					req.func <= it.func;
					req.client <= it.client;
					req.sample_time <= it.stamp;
					req.origin_x <= it.box[0];
					req.origin_y <= it.box[1];
					req.origin_z <= it.box[2];
					req.low_corner_x <= it.box[3];
					req.low_corner_y <= it.box[4];
					req.low_corner_z <= it.box[5];
					req.high_corner_x <= it.box[6];
					req.high_corner_y <= it.box[7];
					req.high_corner_z <= it.box[8];
				end else begin
					req.valid <= 1'b0;
				end
			end
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: predicts at request acceptance, checks at response acceptance.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) begin
				req_item_t it;
				it.func = req.func;
				it.client = req.client;
				it.stamp = req.sample_time;
				it.box = {req.high_corner_z, req.high_corner_y, req.high_corner_x,
					req.low_corner_z, req.low_corner_y, req.low_corner_x,
					req.origin_z, req.origin_y, req.origin_x};
				expected_rsps.push_back(predict_history(it));
				void'(pending_reqs.pop_front());
				req_taken = 1'b1;
				n_sent++;
			end
			if (rsp.valid && rsp.ready) begin
				coords_t got;
				rsp_item_t want;
				got = {rsp.res_high_z, rsp.res_high_y, rsp.res_high_x,
					rsp.res_low_z, rsp.res_low_y, rsp.res_low_x,
					rsp.res_origin_z, rsp.res_origin_y, rsp.res_origin_x};
				n_rsps++;
				if (expected_rsps.size() == 0) begin
					$error("unexpected response transaction");
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (want.found) n_found++;
					if (rsp.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp.found);
						errors++;
					end
					for (int k = 0; k < NCOORD; k++) begin
						if (got[k] !== want.box[k]) begin
							$error("coordinate %0d: expected %0h, got %0h",
								k, want.box[k], got[k]);
							errors++;
						end
					end
				end
			end
			// Watchdog on lack of progress on either channel.
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else if (pending_reqs.size() != 0 || expected_rsps.size() != 0)
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT && !timed_out) begin
				timed_out = 1;
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("FAIL timestamped_position_history_interp");
				$finish;
			end
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(int'($urandom_range(2000)) - 1000);
			default: return $urandom();
		endcase
	endfunction

	function automatic req_item_t make_item(logic [1:0] f, int c, logic [31:0] t);
		req_item_t it;
		it.func = f;
		it.client = 6'(c);
		it.stamp = t;
		for (int k = 0; k < NCOORD; k++) it.box[k] = rand_coord();
		return it;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
		// Allow the slowest query to finish before touching the registers.
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [6:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_HISTORY_SLOTS) ring_cfg = val[5:0];
		else limit_cfg = val;
	endtask

	// A session mostly on the first client_span clients: monotonic records and queries
	// that straddle them, with clears, broken ordering and unknown operations mixed in.
	task automatic queue_session(int count, int client_span);
		int c;
		logic [31:0] t;
		int base_t [N_CLIENTS];
		for (int i = 0; i < N_CLIENTS; i++) base_t[i] = int'($urandom_range(1000)) - 500;
		for (int i = 0; i < count; i++) begin
			c = $urandom_range(client_span - 1);
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7: begin
					base_t[c] += $urandom_range(20);
					t = base_t[c];
					if ($urandom_range(9) == 0) t = $urandom();
					pending_reqs.push_back(make_item(FUNC_RECORD, c, t));
				end
				8, 9, 10, 11, 12, 13, 14, 15, 16: begin
					t = base_t[c] - int'($urandom_range(200)) + 10;
					if ($urandom_range(9) == 0) t = $urandom();
					pending_reqs.push_back(make_item(FUNC_QUERY, c, t));
				end
				17: pending_reqs.push_back(make_item(FUNC_CLEAR, c, $urandom()));
				18: pending_reqs.push_back(make_item(2'd3, $urandom_range(63), $urandom()));
				default: pending_reqs.push_back(
					make_item(2'($urandom_range(2)), $urandom_range(63), $urandom()));
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = 1'b0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.func = '0;
		req.client = '0;
		req.sample_time = '0;
		req.origin_x = '0; req.origin_y = '0; req.origin_z = '0;
		req.low_corner_x = '0; req.low_corner_y = '0; req.low_corner_z = '0;
		req.high_corner_x = '0; req.high_corner_y = '0; req.high_corner_z = '0;
		rsp.ready = 1'b0;
		ring_cfg = HISTORY_SLOTS_RST;
		limit_cfg = CLIENT_LIMIT_RST;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		errors = 0;
		n_sent = 0; n_rsps = 0; n_found = 0; idle_cycles = 0; timed_out = 0;
		req_taken = 0;
		for (int c = 0; c < N_CLIENTS; c++) begin
			hist_head[c] = 0;
			hist_fill[c] = 0;
			for (int s = 0; s < N_SLOTS; s++) hist_valid[c][s] = 0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: miss on empty ring, extremes, equal times, unknown operation
		// and ring wrap-around.
		pending_reqs.push_back(make_item(FUNC_QUERY, 3, 32'd0));
		pending_reqs.push_back(make_item(FUNC_RECORD, 3, 32'h8000_0000));
		pending_reqs.push_back(make_item(FUNC_QUERY, 3, 32'h8000_0000));
		pending_reqs.push_back(make_item(FUNC_RECORD, 3, 32'h7fff_ffff));
		pending_reqs.push_back(make_item(FUNC_QUERY, 3, 32'd0));
		pending_reqs.push_back(make_item(FUNC_QUERY, 3, 32'h7fff_ffff));
		pending_reqs.push_back(make_item(FUNC_RECORD, 63, 32'd100));
		pending_reqs.push_back(make_item(FUNC_RECORD, 63, 32'd100));
		pending_reqs.push_back(make_item(FUNC_QUERY, 63, 32'd100));
		pending_reqs.push_back(make_item(FUNC_RECORD, 63, 32'd103));
		pending_reqs.push_back(make_item(FUNC_QUERY, 63, 32'd101));
		pending_reqs.push_back(make_item(FUNC_QUERY, 63, 32'd99));
		pending_reqs.push_back(make_item(2'd3, 63, 32'd101));
		pending_reqs.push_back(make_item(FUNC_CLEAR, 63, 32'd0));
		pending_reqs.push_back(make_item(FUNC_QUERY, 63, 32'd101));
		for (int i = 0; i < 11; i++)
			pending_reqs.push_back(make_item(FUNC_RECORD, 0, 32'(i * 7)));
		pending_reqs.push_back(make_item(FUNC_QUERY, 0, 32'd30));
		wait_drained();

		// Limit the active clients and shrink the ring without clearing, so
		// stale entries stay visible; clears still reach rejected clients.
		write_reg(REG_CLIENT_LIMIT, 7'd1);
		write_reg(REG_HISTORY_SLOTS, 7'd0);
		pending_reqs.push_back(make_item(FUNC_QUERY, 0, 32'd30));
		pending_reqs.push_back(make_item(FUNC_RECORD, 3, 32'd5));
		pending_reqs.push_back(make_item(FUNC_QUERY, 3, 32'd0));
		pending_reqs.push_back(make_item(FUNC_CLEAR, 3, 32'd0));
		queue_session(60, 4);
		wait_drained();

		// Random phases with different settings and idling mixes.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			case (ph)
				0: write_reg(REG_HISTORY_SLOTS, 7'd4);
				1: write_reg(REG_HISTORY_SLOTS, 7'd32);
				2: write_reg(REG_HISTORY_SLOTS, 7'd63);
				3: write_reg(REG_HISTORY_SLOTS, 7'($urandom_range(5, 31)));
				default: write_reg(REG_HISTORY_SLOTS, 7'($urandom_range(63)));
			endcase
			case (ph)
				0: write_reg(REG_CLIENT_LIMIT, 7'd64);
				3: write_reg(REG_CLIENT_LIMIT, 7'd127);
				5: write_reg(REG_CLIENT_LIMIT, 7'd0);
				default: write_reg(REG_CLIENT_LIMIT, 7'($urandom_range(1, 64)));
			endcase
			queue_session(130, (ph % 2) ? 6 : 64);
			wait_drained();
		end

		$display("Ran %0d transactions with %0d responses, %0d of them found positions,",
			n_sent, n_rsps, n_found);
		$display("over several ring lengths, client limits and handshake stall mixes.");
		if (errors == 0 && expected_rsps.size() == 0)
			$display("PASS timestamped_position_history_interp");
		else
			$display("FAIL timestamped_position_history_interp");
		$finish;
	end

endmodule
